// ===== rtl/core/sida_pkg.sv =====
package sida_pkg;

	localparam int MAG_W      = 32;
	localparam int CMP_W      = 34;
	localparam int POS_W      = 4;
	localparam int NUM_DIGITS = 10;
	localparam int CHAR_W     = 8;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	typedef struct packed {
		logic load;
		logic size;
		logic sign;
		logic step;
	} sida_cmd_t;

	typedef struct packed {
		logic neg;
		logic pos_zero;
	} sida_sts_t;

	function automatic logic [CMP_W-1:0] pow10(input logic [POS_W-1:0] k);
		logic [CMP_W-1:0] p;
		unique case (k)
			4'd0:    p = CMP_W'(1);
			4'd1:    p = CMP_W'(10);
			4'd2:    p = CMP_W'(100);
			4'd3:    p = CMP_W'(1000);
			4'd4:    p = CMP_W'(10000);
			4'd5:    p = CMP_W'(100000);
			4'd6:    p = CMP_W'(1000000);
			4'd7:    p = CMP_W'(10000000);
			4'd8:    p = CMP_W'(100000000);
			4'd9:    p = CMP_W'(1000000000);
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

// ===== rtl/core/sida_dp.sv =====
module sida_dp
	import sida_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  sida_cmd_t         cmd,
	output sida_sts_t         sts,
	input  logic [MAG_W-1:0]  value,
	output logic [CHAR_W-1:0] character,
	output logic              last
);

	logic [MAG_W-1:0]    mag_q;
	logic [POS_W-1:0]    pos_q;
	logic                neg_q;
	logic [CMP_W-1:0]    mag_ext;
	logic [CMP_W-1:0]    pow;
	logic [CMP_W-1:0]    mult [NUM_DIGITS];
	logic [NUM_DIGITS-2:0] ge_mult;
	logic [NUM_DIGITS-2:0] ge_size;
	logic [POS_W-1:0]    digit;
	logic [POS_W-1:0]    ndig_m1;
	logic [CMP_W-1:0]    rest;

	assign mag_ext = {{(CMP_W-MAG_W){1'b0}}, mag_q};
	assign pow     = pow10(pos_q);
	assign mult[0] = '0;

	for (genvar j = 1; j < NUM_DIGITS; j++) begin : g_mult
		assign mult[j]      = CMP_W'(j) * pow;
		assign ge_mult[j-1] = mag_ext >= mult[j];
		assign ge_size[j-1] = mag_ext >= pow10(POS_W'(j));
	end

	assign digit   = POS_W'($countones(ge_mult));
	assign ndig_m1 = POS_W'($countones(ge_size));
	assign rest    = mag_ext - mult[digit];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q <= 1'b0;
			pos_q <= '0;
		end else if (cmd.load) begin
			neg_q <= value[MAG_W-1];
		end else if (cmd.size) begin
			pos_q <= ndig_m1;
		end else if (cmd.step) begin
			pos_q <= pos_q - POS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= value[MAG_W-1] ? (MAG_W'(0) - value) : value;
		end else if (cmd.step) begin
			mag_q <= rest[MAG_W-1:0];
		end
	end

	assign sts.neg      = neg_q;
	assign sts.pos_zero = (pos_q == '0);

	assign character = cmd.sign ? CHAR_MINUS : (CHAR_ZERO + {{(CHAR_W-POS_W){1'b0}}, digit});
	assign last      = !cmd.sign && (pos_q == '0);

endmodule

// ===== rtl/core/sida_ctrl.sv =====
module sida_ctrl
	import sida_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  sida_sts_t sts,
	output sida_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SIZE  = 4'b0010,
		S_SIGN  = 4'b0100,
		S_DIGIT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (s_tvalid) state_d = S_SIZE;
			S_SIZE:  state_d = sts.neg ? S_SIGN : S_DIGIT;
			S_SIGN:  if (m_tready) state_d = S_DIGIT;
			S_DIGIT: if (m_tready && sts.pos_zero) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_SIGN) || (state_q == S_DIGIT);

	assign cmd.load = (state_q == S_IDLE) && s_tvalid;
	assign cmd.size = (state_q == S_SIZE);
	assign cmd.sign = (state_q == S_SIGN);
	assign cmd.step = (state_q == S_DIGIT) && m_tready;

endmodule

// ===== rtl/core/signed_int_to_decimal_ascii.sv =====
// Timing: an accepted value passes through S_SIZE, then S_SIGN or S_DIGIT offers
// the first character. One character per cycle while m_tready is high; a new value
// is taken only in idle. One digit is resolved per step against powers of ten.
// Reset: arst_n clears the controller to idle; the datapath magnitude has no reset.
module signed_int_to_decimal_ascii
	import sida_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [MAG_W-1:0]  s_tdata,  // [31:0] value
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [CHAR_W-1:0] m_tdata,  // [7:0] character
	output logic              m_tlast
);

	sida_cmd_t cmd;
	sida_sts_t sts;

	sida_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sida_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.value     (s_tdata),
		.character (m_tdata),
		.last      (m_tlast)
	);

endmodule
